FILE: hw/rtl/debounced_orientation_classifier_macros.svh
// Assertion macros for the orientation classifier checker.
`ifndef DEBOUNCED_ORIENTATION_CLASSIFIER_MACROS_SVH
`define DEBOUNCED_ORIENTATION_CLASSIFIER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DOC_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define DOC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/doc_pkg.sv
// Shared types and constants of the orientation classifier.
package doc_pkg;
	localparam logic [2:0] CLS_UNKNOWN = 3'd0;
	localparam logic [2:0] CLS_PORTRAIT = 3'd1;
	localparam logic [2:0] CLS_UPSIDE = 3'd2;
	localparam logic [2:0] CLS_LEFT = 3'd3;
	localparam logic [2:0] CLS_RIGHT = 3'd4;
	localparam logic [2:0] CLS_FACE_UP = 3'd5;
	localparam logic [2:0] CLS_FACE_DOWN = 3'd6;
	localparam logic [1:0] REG_FACE_COS = 2'd0;
	localparam logic [1:0] REG_FACE_SIN = 2'd1;
	localparam logic [1:0] REG_AXIS_TAN = 2'd2;
	localparam logic [1:0] REG_DEBOUNCE = 2'd3;
	// Share-unit source selection.
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_INV = 2'd1;
	localparam logic [1:0] SRC_DIRECT = 2'd2;
	typedef struct packed {
		logic [2:0] cls;
		logic [1:0] src;
		logic restarted;
	} doc_ctl_t;
endpackage

FILE: hw/rtl/doc_front.sv
// Front: decode, classify, debounce; issues a share job to the queue.
module doc_front import doc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int STAMP_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [SAMPLE_BITS-1:0] gx,
	input logic [SAMPLE_BITS-1:0] gy,
	input logic [SAMPLE_BITS-1:0] gz,
	input logic [STAMP_BITS-1:0] stamp,
	input logic [15:0] face_cos,
	input logic [15:0] face_sin,
	input logic [16:0] axis_tan,
	input logic [31:0] debounce_us,
	output logic job_valid,
	input logic job_ready,
	output doc_ctl_t job_ctl,
	output logic [SAMPLE_BITS:0] job_c,
	output logic [2*SAMPLE_BITS+1:0] job_s
);
	localparam int MW = SAMPLE_BITS + 1;
	localparam int SW = 2 * SAMPLE_BITS + 2;
	localparam int PW = 2 * SW + 2;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ = 3'd1;
	localparam logic [2:0] ST_THR = 3'd2;
	localparam logic [2:0] ST_CMP = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [MW-1:0] ax_q, ay_q, az_q;
	logic nx_q, ny_q, nz_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [SW-1:0] s_q, zz_q;
	logic [31:0] cos2_q, sin2_q;
	logic face_q, edge_q, diag_q;
	logic [2:0] cur_q, pend_q;
	logic [STAMP_BITS-1:0] since_q, last_q;
	logic hist_q, hasp_q;
	logic [MW-1:0] dom, sec;
	logic [PW-1:0] lhs_z, rhs_cos, rhs_sin;
	logic [MW+17:0] sec_sc, dom_sc;
	logic [2:0] cand;
	logic [1:0] csrc;
	logic [MW-1:0] cval;
	logic hist_e, hasp_e;
	logic [2:0] cur_e, pend_e;
	logic [2:0] cur_n, pend_n;
	logic [STAMP_BITS-1:0] since_n;
	logic hasp_n;
	logic [MW-1:0] cconf;
	logic [1:0] fsrc;
	logic [MW-1:0] fc;
	logic [STAMP_BITS-1:0] dt;

	function automatic logic [MW-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
		mag = v[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, v}) : {1'b0, v};
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign dom = (ax_q > ay_q) ? ax_q : ay_q;
	assign sec = (ax_q > ay_q) ? ay_q : ax_q;
	assign lhs_z = PW'({zz_q, 32'd0});
	assign rhs_cos = PW'(cos2_q) * PW'(s_q);
	assign rhs_sin = PW'(sin2_q) * PW'(s_q);
	assign sec_sc = (MW+18)'({sec, 16'd0});
	assign dom_sc = (MW+18)'(axis_tan) * (MW+18)'(dom);
	assign dt = stamp_q - since_q;

	// Classify the sample.
	always_comb begin
		cand = CLS_UNKNOWN;
		csrc = SRC_NONE;
		cval = '0;
		if (s_q != '0) begin
			if (face_q) begin
				cand = nz_q ? CLS_FACE_UP : CLS_FACE_DOWN;
			end else if (edge_q || dom == '0) begin
				csrc = SRC_INV;
				cval = az_q;
			end else if (diag_q) begin
				csrc = SRC_INV;
				cval = dom;
			end else if (ax_q > ay_q) begin
				cand = nx_q ? CLS_PORTRAIT : CLS_UPSIDE;
			end else begin
				cand = ny_q ? CLS_LEFT : CLS_RIGHT;
			end
		end
	end

	// Apply restart, then debounce.
	always_comb begin
		hist_e = hist_q;
		hasp_e = hasp_q;
		cur_e = cur_q;
		pend_e = pend_q;
		if (hist_q && stamp_q <= last_q) begin
			hist_e = 1'b0;
			hasp_e = 1'b0;
			cur_e = CLS_UNKNOWN;
			pend_e = CLS_UNKNOWN;
		end
		cur_n = cur_e;
		pend_n = pend_e;
		since_n = since_q;
		hasp_n = hasp_e;
		if (!hist_e) begin
			cur_n = (debounce_us == '0) ? cand : CLS_UNKNOWN;
			if (cur_n != cand) begin
				pend_n = cand;
				since_n = stamp_q;
				hasp_n = 1'b1;
			end
		end else if (cand == cur_e) begin
			hasp_n = 1'b0;
		end else if (debounce_us == '0) begin
			cur_n = cand;
			hasp_n = 1'b0;
		end else if (!hasp_e || pend_e != cand) begin
			pend_n = cand;
			since_n = stamp_q;
			hasp_n = 1'b1;
		end else if (64'(dt) >= 64'(debounce_us)) begin
			cur_n = cand;
			hasp_n = 1'b0;
		end
	end

	// Pick the confidence job.
	always_comb begin
		fsrc = SRC_NONE;
		fc = '0;
		cconf = '0;
		case (cur_n)
			CLS_UNKNOWN: cconf = '0;
			CLS_PORTRAIT: cconf = nx_q ? ax_q : '0;
			CLS_UPSIDE: cconf = nx_q ? '0 : ax_q;
			CLS_LEFT: cconf = ny_q ? ay_q : '0;
			CLS_RIGHT: cconf = ny_q ? '0 : ay_q;
			CLS_FACE_UP: cconf = nz_q ? az_q : '0;
			default: cconf = nz_q ? '0 : az_q;
		endcase
		if (cur_n == CLS_UNKNOWN) begin
			if (cand == CLS_UNKNOWN) begin
				fsrc = csrc;
				fc = cval;
			end
		end else if (s_q != '0) begin
			fsrc = SRC_DIRECT;
			fc = cconf;
		end
	end

	// Sequence one sample through square, threshold, compare and hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= CLS_UNKNOWN;
			pend_q <= CLS_UNKNOWN;
			since_q <= '0;
			last_q <= '0;
			hist_q <= 1'b0;
			hasp_q <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_THR;
				ST_THR: state_q <= ST_CMP;
				ST_CMP: begin
					cur_q <= cur_n;
					pend_q <= pend_n;
					since_q <= since_n;
					hasp_q <= hasp_n;
					hist_q <= 1'b1;
					last_q <= stamp_q;
					job_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (job_ready) begin
						job_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold sample data and intermediate products.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ax_q <= mag(gx);
			ay_q <= mag(gy);
			az_q <= mag(gz);
			nx_q <= gx[SAMPLE_BITS-1];
			ny_q <= gy[SAMPLE_BITS-1];
			nz_q <= gz[SAMPLE_BITS-1];
			stamp_q <= stamp;
		end
		if (state_q == ST_SQ) begin
			s_q <= SW'(ax_q * ax_q) + SW'(ay_q * ay_q) + SW'(az_q * az_q);
			zz_q <= SW'(az_q * az_q);
			cos2_q <= 32'(face_cos) * 32'(face_cos);
			sin2_q <= 32'(face_sin) * 32'(face_sin);
		end
		if (state_q == ST_CMP) begin
			job_ctl.cls <= cur_n;
			job_ctl.src <= fsrc;
			job_ctl.restarted <= !hist_e;
			job_c <= fc;
			job_s <= s_q;
		end
	end

	// Register the threshold compares once squares are known.
	always_ff @(posedge clk) begin
		face_q <= lhs_z >= rhs_cos;
		edge_q <= lhs_z > rhs_sin;
		diag_q <= sec_sc > dom_sc;
	end
endmodule

FILE: hw/rtl/doc_queue.sv
// Two-entry queue between front and back.
module doc_queue import doc_pkg::*; #(
	parameter int DW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input logic [DW-1:0] wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	// Store entries.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: hw/rtl/doc_back.sv
// Back: bit-serial Q16 share unit and output register.
module doc_back import doc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input doc_ctl_t job_ctl,
	input logic [SAMPLE_BITS:0] job_c,
	input logic [2*SAMPLE_BITS+1:0] job_s,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] out_cls,
	output logic [16:0] out_conf,
	output logic out_restart
);
	localparam int SW = 2 * SAMPLE_BITS + 2;
	localparam int PW = SW + 34;
	logic busy_q;
	logic [4:0] bit_q;
	logic [16:0] q_q;
	doc_ctl_t ctl_q;
	logic [SW-1:0] cc_q, s_q;
	logic [PW-1:0] p_q, qs_q;
	logic [16:0] t;
	logic [PW-1:0] lhs, rhs;
	logic fit;

	assign job_ready = !busy_q && !out_valid;
	assign t = q_q | (17'd1 << bit_q);
	// (q + 2^b)^2 * s from the running q^2 * s and q * s
	assign lhs = p_q + (qs_q << (bit_q + 5'd1)) + (PW'(s_q) << {bit_q, 1'b0});
	assign rhs = PW'({cc_q, 32'd0});
	assign fit = (t <= 17'd65536) && (lhs <= rhs);

	// Iterate one result bit per cycle, MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (job_valid && job_ready) begin
				busy_q <= (job_ctl.src != SRC_NONE);
				out_valid <= (job_ctl.src == SRC_NONE);
			end else if (busy_q && bit_q == 5'd0) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			ctl_q <= job_ctl;
			cc_q <= SW'(job_c * job_c);
			s_q <= job_s;
			q_q <= '0;
			p_q <= '0;
			qs_q <= '0;
			bit_q <= 5'd16;
			out_cls <= job_ctl.cls;
			out_restart <= job_ctl.restarted;
			out_conf <= '0;
		end else if (busy_q) begin
			if (fit) begin
				q_q <= t;
				p_q <= lhs;
				qs_q <= qs_q + (PW'(s_q) << bit_q);
			end
			if (bit_q == 5'd0) begin
				out_conf <= (ctl_q.src == SRC_INV) ? 17'(17'd65536 - (fit ? t : q_q))
					: (fit ? t : q_q);
			end else begin
				bit_q <= bit_q - 5'd1;
			end
		end
	end
endmodule

FILE: hw/rtl/debounced_orientation_classifier.sv
// Top level of the debounced orientation classifier.
// Usage:
//  s_axis carries one gravity sample per transaction: tdata holds gx, gy, gz
//  and stamp_us from the lowest bit up. m_axis returns one result per sample:
//  orientation, confidence, state_restarted.
//  The APB port writes face_cos (0x0), face_sin (0x4), axis_tan (0x8) and
//  debounce_us (0xC); write only while no sample is in flight.
// Flow: the front accepts, squares, thresholds and commits a sample, then hands
//  the job to the two-entry queue; the share unit computes the 17 confidence
//  bits, one confidence bit per cycle, when a confidence share is needed.
// The front takes no new sample until its hand-off completes (accept, square,
//  threshold, commit, hand-off); the share unit takes no new job while busy or while its result waits.
// Reset clears class, pending, history and registers to their defaults.
// A stalled m_axis fills the two-entry queue, after which s_axis_tready falls.
module debounced_orientation_classifier import doc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int STAMP_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// gx, gy, gz, stamp_us from bit 0 up, zero-padded to whole bytes
	input logic [((3*SAMPLE_BITS+STAMP_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// orientation[2:0], confidence[19:3], state_restarted[20], pad
	output logic [23:0] m_axis_tdata,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int DW = 6 + SAMPLE_BITS + 1 + 2 * SAMPLE_BITS + 2;
	logic [15:0] face_cos_q, face_sin_q;
	logic [16:0] axis_tan_q;
	logic [31:0] debounce_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	doc_ctl_t fj_ctl, bj_ctl;
	logic [SAMPLE_BITS:0] fj_c, bj_c;
	logic [2*SAMPLE_BITS+1:0] fj_s, bj_s;
	logic [2:0] o_cls;
	logic [16:0] o_conf;
	logic o_rst;

	assign pready = 1'b1;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_cos_q <= 16'd56756;
			face_sin_q <= 16'd32768;
			axis_tan_q <= 17'd54991;
			debounce_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_FACE_COS: face_cos_q <= pwdata[15:0];
				REG_FACE_SIN: face_sin_q <= pwdata[15:0];
				REG_AXIS_TAN: axis_tan_q <= pwdata[16:0];
				REG_DEBOUNCE: debounce_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (paddr[3:2])
			REG_FACE_COS: prdata = {16'd0, face_cos_q};
			REG_FACE_SIN: prdata = {16'd0, face_sin_q};
			REG_AXIS_TAN: prdata = {15'd0, axis_tan_q};
			REG_DEBOUNCE: prdata = debounce_q;
			default: prdata = '0;
		endcase
	end

	doc_front #(.SAMPLE_BITS(SAMPLE_BITS), .STAMP_BITS(STAMP_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.gx(s_axis_tdata[SAMPLE_BITS-1:0]),
		.gy(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.gz(s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
		.stamp(s_axis_tdata[3*SAMPLE_BITS+STAMP_BITS-1:3*SAMPLE_BITS]),
		.face_cos(face_cos_q), .face_sin(face_sin_q),
		.axis_tan(axis_tan_q), .debounce_us(debounce_q),
		.job_valid(fj_valid), .job_ready(fj_ready),
		.job_ctl(fj_ctl), .job_c(fj_c), .job_s(fj_s)
	);

	doc_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready),
		.wr_data({fj_ctl, fj_c, fj_s}),
		.rd_valid(bj_valid), .rd_ready(bj_ready),
		.rd_data({bj_ctl, bj_c, bj_s})
	);

	doc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready),
		.job_ctl(bj_ctl), .job_c(bj_c), .job_s(bj_s),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_cls(o_cls), .out_conf(o_conf), .out_restart(o_rst)
	);

	assign m_axis_tdata = {3'd0, o_rst, o_conf, o_cls};
endmodule

FILE: hw/rtl/doc_checker.sv
// Port-level checker for the orientation classifier, bound to the top level.
`include "debounced_orientation_classifier_macros.svh"
module doc_checker import doc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic pready
);
	`DOC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`DOC_ASSERT_IMP(a_cls_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7)
	`DOC_ASSERT_IMP(a_conf_range, clk, arst_n, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[18:3] == 16'd0)
	`DOC_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind debounced_orientation_classifier doc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the debounced orientation classifier.
`timescale 1ns / 100ps

module tb_top;
	import doc_pkg::*;

	typedef struct {
		logic [2:0] cls;
		logic [16:0] conf;
		logic restarted;
	} orient_t;

	typedef struct {
		logic [15:0] gx, gy, gz;
		logic [31:0] stamp;
		logic known;
		orient_t want;
	} stim_row_t;

	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// gx, gy, gz, stamp_us from bit 0 up
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// orientation[2:0], confidence[19:3], state_restarted[20], pad
	logic [23:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Classifier copy: registers and tracking state
	logic [15:0] face_cos, face_sin;
	logic [16:0] axis_tan;
	logic [31:0] debounce_us;
	logic [2:0] cur_cls, pend_cls;
	logic [31:0] pend_since, last_stamp;
	logic has_hist, has_pend;

	orient_t pending_results[$];
	stim_row_t dir_rows[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_restarts = 0;
	int cls_seen[7];
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	debounced_orientation_classifier u_dut (.*);

	always #5 clk = ~clk;

	task automatic report(input string what, input longint want, input longint got);
		$display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	// floor(65536 * c / sqrt(s)), one bit at a time
	function automatic logic [16:0] share(input logic [16:0] c, input logic [34:0] s);
		logic [16:0] q, t;
		q = '0;
		for (int b = 16; b >= 0; b--) begin
			t = q | (17'd1 << b);
			if (t <= 17'd65536 &&
					128'(t) * 128'(t) * 128'(s) <= (128'(c) * 128'(c) << 32))
				q = t;
		end
		return q;
	endfunction

	function automatic logic [16:0] magnitude(input logic [15:0] v);
		return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
	endfunction

	// Advance the classifier copy by one sample and return its result
	function automatic orient_t classify(input logic [15:0] gx, gy, gz, input logic [31:0] st);
		logic [16:0] ax, ay, az, dom, sec, cand_conf, c;
		logic [34:0] s;
		logic [2:0] cand;
		orient_t r;
		ax = magnitude(gx);
		ay = magnitude(gy);
		az = magnitude(gz);
		s = 35'(ax) * ax + 35'(ay) * ay + 35'(az) * az;
		dom = ax > ay ? ax : ay;
		sec = ax > ay ? ay : ax;
		cand = CLS_UNKNOWN;
		cand_conf = '0;
		r.restarted = 1'b0;
		r.conf = '0;
		// drop all history on a timestamp that does not advance
		if (has_hist && st <= last_stamp) begin
			cur_cls = CLS_UNKNOWN;
			pend_cls = CLS_UNKNOWN;
			pend_since = '0;
			last_stamp = '0;
			has_hist = 1'b0;
			has_pend = 1'b0;
		end
		if (s != 0) begin
			if ((128'(az) * az << 32) >= 128'(face_cos) * face_cos * s)
				cand = gz[15] ? CLS_FACE_UP : CLS_FACE_DOWN;
			else if ((128'(az) * az << 32) > 128'(face_sin) * face_sin * s || dom == 0)
				cand_conf = 17'd65536 - share(az, s);
			else if (64'(sec) * 65536 > 64'(axis_tan) * dom)
				cand_conf = 17'd65536 - share(dom, s);
			else if (ax > ay)
				cand = gx[15] ? CLS_PORTRAIT : CLS_UPSIDE;
			else
				cand = gy[15] ? CLS_LEFT : CLS_RIGHT;
		end
		// debounce the candidate class
		if (!has_hist) begin
			has_hist = 1'b1;
			cur_cls = debounce_us == 0 ? cand : CLS_UNKNOWN;
			if (cur_cls != cand) begin
				pend_cls = cand;
				pend_since = st;
				has_pend = 1'b1;
			end
			r.restarted = 1'b1;
		end else if (cand == cur_cls) begin
			has_pend = 1'b0;
		end else if (debounce_us == 0) begin
			cur_cls = cand;
			has_pend = 1'b0;
		end else if (!has_pend || pend_cls != cand) begin
			pend_cls = cand;
			pend_since = st;
			has_pend = 1'b1;
		end else if (st - pend_since >= debounce_us) begin
			cur_cls = cand;
			has_pend = 1'b0;
		end
		last_stamp = st;
		if (cur_cls == CLS_UNKNOWN) begin
			r.conf = cand == CLS_UNKNOWN ? cand_conf : '0;
		end else if (s != 0) begin
			case (cur_cls)
				CLS_PORTRAIT: c = gx[15] ? ax : '0;
				CLS_UPSIDE: c = gx[15] ? '0 : ax;
				CLS_LEFT: c = gy[15] ? ay : '0;
				CLS_RIGHT: c = gy[15] ? '0 : ay;
				CLS_FACE_UP: c = gz[15] ? az : '0;
				default: c = gz[15] ? '0 : az;
			endcase
			r.conf = share(c, s);
		end
		r.cls = cur_cls;
		return r;
	endfunction

	task automatic add_row(input int gx, gy, gz, input logic [31:0] st, input logic known,
			input logic [2:0] cls, input int conf, input logic rst);
		stim_row_t row;
		row.gx = 16'(gx);
		row.gy = 16'(gy);
		row.gz = 16'(gz);
		row.stamp = st;
		row.known = known;
		row.want.cls = cls;
		row.want.conf = 17'(conf);
		row.want.restarted = rst;
		dir_rows.push_back(row);
	endtask

	// Register write: setup cycle, then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_FACE_COS: face_cos = val[15:0];
			REG_FACE_SIN: face_sin = val[15:0];
			REG_AXIS_TAN: axis_tan = val[16:0];
			default: debounce_us = val;
		endcase
	endtask

	// Wait out every result, then the pipeline latency
	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one sample and hold it until the transaction completes
	task automatic send(input logic [15:0] gx, gy, gz, input logic [31:0] st,
			input logic known, input orient_t want);
		orient_t r;
		if (!steady && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {st, gz, gy, gx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = classify(gx, gy, gz, st);
		pending_results.push_back(known ? want : r);
		n_sent++;
	endtask

	function automatic logic [15:0] rand_axis();
		int m;
		m = $urandom_range(0, 9) == 0 ? 32768 : $urandom_range(4000, 32767);
		return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
	endfunction

	function automatic logic [15:0] rand_noise();
		int n;
		n = $urandom_range(0, 20000);
		return 16'($urandom_range(0, 1) ? -n : n);
	endfunction

	// Random samples: mostly gravity near one axis, with extremes and noise
	task automatic random_phase(input int count);
		logic [15:0] v[3];
		logic [31:0] st;
		orient_t none;
		int ax;
		none = '{default: '0};
		st = $urandom();
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 11))
				0, 1: foreach (v[k]) v[k] = 16'($urandom());
				2: foreach (v[k])
					case ($urandom_range(0, 4))
						0: v[k] = 16'h8000;
						1: v[k] = 16'h7FFF;
						2: v[k] = 16'hFFFF;
						3: v[k] = 16'h0001;
						default: v[k] = '0;
					endcase
				3: begin
					v[0] = rand_axis();
					v[1] = $urandom_range(0, 1) ? v[0] : 16'(-v[0]);
					v[2] = 16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 3000));
				end
				4: foreach (v[k]) v[k] = $urandom_range(0, 3) == 0 ? '0 : 16'($urandom_range(0, 3));
				default: begin
					ax = $urandom_range(0, 2);
					foreach (v[k]) v[k] = k == ax ? rand_axis() : rand_noise();
				end
			endcase
			// occasionally step the timestamp backward or repeat it
			case ($urandom_range(0, 29))
				0: st = st - $urandom_range(0, 1000);
				1: st = $urandom();
				default: st = st + $urandom_range(1, 400);
			endcase
			send(v[0], v[1], v[2], st, 1'b0, none);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Check each returned result against the oldest prediction
	always @(posedge clk) begin
		orient_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 0, m_axis_tdata);
			end else begin
				w = pending_results.pop_front();
				if (m_axis_tdata[2:0] !== w.cls)
					report("orientation", w.cls, m_axis_tdata[2:0]);
				if (m_axis_tdata[19:3] !== w.conf)
					report("confidence", w.conf, m_axis_tdata[19:3]);
				if (m_axis_tdata[20] !== w.restarted)
					report("state_restarted", w.restarted, m_axis_tdata[20]);
				n_checked++;
				n_restarts += w.restarted;
				if (w.cls <= CLS_FACE_DOWN)
					cls_seen[w.cls]++;
			end
		end
	end

	// Result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= steady || $urandom_range(0, 99) >= 15;
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("FAIL debounced_orientation_classifier");
			$finish;
		end
	end

	initial begin
		face_cos = 16'd56756;
		face_sin = 16'd32768;
		axis_tan = 17'd54991;
		debounce_us = '0;
		cur_cls = CLS_UNKNOWN;
		pend_cls = CLS_UNKNOWN;
		pend_since = '0;
		last_stamp = '0;
		has_hist = 1'b0;
		has_pend = 1'b0;
		foreach (cls_seen[k]) cls_seen[k] = 0;

		// directed rows at reset settings
		add_row(0, 0, 16384, 10, 1, CLS_FACE_DOWN, 65536, 1);
		add_row(0, 0, 0, 20, 1, CLS_UNKNOWN, 0, 0);
		add_row(-32768, 0, 0, 30, 1, CLS_PORTRAIT, 65536, 0);
		add_row(32767, 0, 0, 40, 1, CLS_UPSIDE, 65536, 0);
		add_row(0, -32768, 0, 50, 1, CLS_LEFT, 65536, 0);
		add_row(0, 32767, 0, 60, 1, CLS_RIGHT, 65536, 0);
		add_row(0, 0, -32768, 70, 1, CLS_FACE_UP, 65536, 0);
		add_row(-32768, -32768, -32768, 80, 0, 0, 0, 0);
		add_row(100, 100, 0, 90, 0, 0, 0, 0);
		add_row(-20000, 20000, 0, 95, 0, 0, 0, 0);
		add_row(1000, 0, 1000, 100, 0, 0, 0, 0);
		add_row(0, 0, 0, 110, 1, CLS_UNKNOWN, 0, 0);
		add_row(0, 0, 500, 110, 1, CLS_FACE_DOWN, 65536, 1);
		add_row(0, 0, -1, 5, 1, CLS_FACE_UP, 65536, 1);
		add_row(1, -1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(32767, 32767, 32767, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(-1, 0, 0, 32'h8000_0000, 1, CLS_PORTRAIT, 65536, 1);
		add_row(-3000, 2000, 0, 32'h8000_0001, 0, 0, 0, 0);
		add_row(30000, 2000, -200, 32'h8000_0002, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].gx, dir_rows[i].gy, dir_rows[i].gz, dir_rows[i].stamp,
				dir_rows[i].known, dir_rows[i].want);
		s_axis_tvalid <= 1'b0;
		drain();

		// reset settings, no stalls at all
		steady = 1'b1;
		random_phase(250);
		drain();
		steady = 1'b0;

		// widest cone, edge band and dead zone, immediate adoption
		reg_write(REG_FACE_COS, 32'd46341);
		reg_write(REG_FACE_SIN, 32'd1);
		reg_write(REG_AXIS_TAN, 32'd1);
		random_phase(200);
		drain();

		// narrowest cone and edge band, no dead zone, with a short debounce; hold the result side off
		reg_write(REG_FACE_COS, 32'hFFFF_FFFF);
		reg_write(REG_FACE_SIN, 32'd46340);
		reg_write(REG_AXIS_TAN, 32'd65536);
		reg_write(REG_DEBOUNCE, 32'd150);
		hold_req = 1'b1;
		random_phase(300);
		drain();

		// debounce that never expires
		reg_write(REG_DEBOUNCE, 32'hFFFF_FFFF);
		reg_write(REG_FACE_COS, 32'd56756);
		reg_write(REG_FACE_SIN, 32'd32768);
		random_phase(150);
		drain();

		// random in-range settings, random debounce
		for (int p = 0; p < 3; p++) begin
			reg_write(REG_FACE_COS, $urandom_range(46341, 65535));
			reg_write(REG_FACE_SIN, $urandom_range(1, 46340));
			reg_write(REG_AXIS_TAN, $urandom_range(1, 65536));
			reg_write(REG_DEBOUNCE, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1200));
			random_phase(180);
			drain();
		end

		$display("covered %0d samples, %0d results checked, %0d state restarts",
			n_sent, n_checked, n_restarts);
		$display("classes 0..6 seen: %0d %0d %0d %0d %0d %0d %0d", cls_seen[0], cls_seen[1],
			cls_seen[2], cls_seen[3], cls_seen[4], cls_seen[5], cls_seen[6]);
		if (errors == 0 && pending_results.size() == 0)
			$display("PASS debounced_orientation_classifier");
		else
			$display("FAIL debounced_orientation_classifier");
		$finish;
	end

endmodule
